[src/btcr_pkg.sv]
package btcr_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PLANE,
    ST_SCROLL,
    ST_CLR_LINE,
    ST_CLR_SCREEN
  } state_e;

  // Input operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_WRITE     = 2'd0;
  localparam logic [1:0] KIND_SCROLL    = 2'd1;
  localparam logic [1:0] KIND_CLR_LINE  = 2'd2;
  localparam logic [1:0] KIND_CLR_SCREEN = 2'd3;

  // Configuration register indexes
  localparam logic CFG_COLOR_MODE = 1'b0;
  localparam logic CFG_ATTRIBUTE  = 1'b1;

  // Control characters
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // Geometry; one text line is 1280 bytes in both modes
  localparam int unsigned LineBytes   = 1280;
  localparam logic [6:0]  COLS_MONO   = 7'd80;
  localparam logic [6:0]  COLS_COLOR  = 7'd40;
  localparam logic [14:0] STRIDE_MONO = 15'd80;
  localparam logic [14:0] STRIDE_COLOR = 15'd160;
  localparam logic [3:0]  ROWS_MONO   = 4'd15;
  localparam logic [3:0]  ROWS_COLOR  = 4'd7;
  localparam logic [1:0]  PLANES_COLOR = 2'd3;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam int unsigned GlyphEntries = 4096;

endpackage

[src/btcr_ram.sv]
module btcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bitplane_text_console_renderer.sv]
// Channel  Dir  Beat content (tdata / tuser / tlast)
// s_axis   in   char_code, glyph_index, glyph_byte / opcode / -
// m_axis   out  byte_offset, byte_value / kind / last
// cfg      in   index 0 color_mode, index 1 text_attribute
//
// A drawn character keeps the input off after its beat while the sequencer does
// a glyph store read, then one beat per plane, per glyph row, so a new beat is
// taken only once the last character is through. A wrap past the last row adds
// two command beats; tab, newline and glyph loads keep the sequencer idle unless
// a tab or newline wraps past the last row. Reset homes the cursor; the glyph store
// is not cleared. Output stalls hold the sequencer; input is taken only while it is idle.
module bitplane_text_console_renderer #(
  parameter int unsigned TEXT_LINES = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [7:0] char_code, [19:8] glyph_index,
                                     // [27:20] glyph_byte, [31:28] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [14:0] byte_offset, [22:15] byte_value,
                                     // [23] zero
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast
);

  import btcr_pkg::*;

  localparam logic [14:0] ClrLineOff = 15'((TEXT_LINES - 1) * LineBytes);
  localparam logic [4:0]  LastRow    = 5'(TEXT_LINES - 1);
  localparam logic [6:0]  Lines      = 7'(TEXT_LINES);

  state_e      state_q, state_d;
  logic        mode_q;
  logic [7:0]  attr_q;
  logic [6:0]  col_q, col_d;
  logic [4:0]  row_q, row_d;
  logic [7:0]  ch_q, ch_d;
  logic [3:0]  gi_q, gi_d;
  logic [1:0]  pj_q, pj_d;
  logic [14:0] line_off_q, line_off_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_kind_q, out_kind_d;
  logic [14:0] out_off_q, out_off_d;
  logic [7:0]  out_val_q, out_val_d;
  logic        out_last_q, out_last_d;

  logic        accept;
  logic [1:0]  in_op;
  logic [7:0]  in_char;
  logic [11:0] in_gidx;
  logic [7:0]  in_gbyte;
  logic [7:0]  glyph;
  logic        ram_re;
  logic        out_free;
  logic [6:0]  columns;
  logic [14:0] stride;
  logic        last_plane, last_row;
  logic [7:0]  col_inc, tab_col;
  logic        col_wrap;
  logic [5:0]  next_row;
  logic        row_wrap;
  logic [14:0] base_off, row_base, col_part;
  logic        fg, bg;
  logic [7:0]  pix;

  // Unpack input beat
  assign in_op    = s_axis_tuser;
  assign in_char  = s_axis_tdata[7:0];
  assign in_gidx  = s_axis_tdata[19:8];
  assign in_gbyte = s_axis_tdata[27:20];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Glyph store
  btcr_ram #(
    .WIDTH (8),
    .DEPTH (GlyphEntries)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (in_op == OP_LOAD)),
    .waddr_i (in_gidx),
    .wdata_i (in_gbyte),
    .re_i    (ram_re),
    .raddr_i ({gi_q, ch_q}),
    .rdata_o (glyph)
  );
  assign ram_re = (state_q == ST_READ);

  // Mode geometry
  assign columns    = mode_q ? COLS_COLOR : COLS_MONO;
  assign stride     = mode_q ? STRIDE_COLOR : STRIDE_MONO;
  assign last_plane = mode_q ? (pj_q == PLANES_COLOR) : 1'b1;
  assign last_row   = mode_q ? (gi_q == ROWS_COLOR) : (gi_q == ROWS_MONO);

  // Cursor arithmetic
  assign col_inc  = {1'b0, col_q} + 8'd1;
  assign col_wrap = (col_inc >= {1'b0, columns});
  assign tab_col  = {1'b0, col_q[6:3], 3'b000} + 8'd8;
  assign next_row = {1'b0, row_q} + 6'd1;
  assign row_wrap = ({1'b0, next_row} >= Lines);

  // Offset of glyph row 0, plane 0 at the cursor
  assign row_base = {row_q, 10'b0} + {2'b00, row_q, 8'b0};
  assign col_part = mode_q ? {6'b0, col_q[6:1], 3'b000} : {8'b0, col_q[6:1], 1'b0};
  assign base_off = {14'b0, col_q[0]} + col_part + row_base;

  // Plane pixel byte
  assign fg  = attr_q[{1'b0, pj_q}];
  assign bg  = attr_q[{1'b1, pj_q}];
  assign pix = ({8{fg}} & glyph) | ({8{bg}} & ~glyph);

  // Sequencer: next state and result beats
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    ch_d        = ch_q;
    gi_d        = gi_q;
    pj_d        = pj_q;
    line_off_d  = line_off_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_off_d   = out_off_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_PUT: begin
              unique case (in_char) inside
                CH_TAB: begin
                  if (tab_col < {1'b0, columns}) begin
                    col_d = tab_col[6:0];
                  end else begin
                    col_d = '0;
                    if (row_wrap) begin
                      row_d   = LastRow;
                      state_d = ST_SCROLL;
                    end else begin
                      row_d = next_row[4:0];
                    end
                  end
                end
                CH_LF, CH_CR: begin
                  col_d = '0;
                  if (row_wrap) begin
                    row_d   = LastRow;
                    state_d = ST_SCROLL;
                  end else begin
                    row_d = next_row[4:0];
                  end
                end
                default: begin
                  ch_d       = in_char;
                  gi_d       = '0;
                  pj_d       = '0;
                  line_off_d = base_off;
                  state_d    = ST_READ;
                end
              endcase
            end
            OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              state_d = ST_CLR_SCREEN;
            end
            default: begin
              // glyph load is done by the store write port; drop unused code
            end
          endcase
        end
      end

      ST_READ: begin
        state_d = ST_PLANE;
      end

      ST_PLANE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_WRITE;
          out_off_d   = line_off_q + {12'b0, pj_q, 1'b0};
          out_val_d   = pix;
          out_last_d  = last_plane && last_row && !(col_wrap && row_wrap);
          if (!last_plane) begin
            pj_d = pj_q + 2'd1;
          end else begin
            pj_d = '0;
            if (!last_row) begin
              gi_d       = gi_q + 4'd1;
              line_off_d = line_off_q + stride;
              state_d    = ST_READ;
            end else if (!col_wrap) begin
              col_d   = col_inc[6:0];
              state_d = ST_IDLE;
            end else begin
              col_d = '0;
              if (row_wrap) begin
                row_d   = LastRow;
                state_d = ST_SCROLL;
              end else begin
                row_d   = next_row[4:0];
                state_d = ST_IDLE;
              end
            end
          end
        end
      end

      ST_SCROLL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_SCROLL;
          out_off_d   = '0;
          out_val_d   = '0;
          out_last_d  = 1'b0;
          state_d     = ST_CLR_LINE;
        end
      end

      ST_CLR_LINE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_CLR_LINE;
          out_off_d   = ClrLineOff;
          out_val_d   = '0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_CLR_SCREEN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_CLR_SCREEN;
          out_off_d   = '0;
          out_val_d   = '0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      attr_q      <= ATTR_RESET;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COLOR_MODE: mode_q <= cfg_data_i[0];
          CFG_ATTRIBUTE:  attr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    gi_q       <= gi_d;
    pj_q       <= pj_d;
    line_off_q <= line_off_d;
    out_kind_q <= out_kind_d;
    out_off_q  <= out_off_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_val_q, out_off_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import btcr_pkg::*;

  localparam int unsigned TEXT_LINES     = 25;
  localparam logic [1:0]  OP_NONE        = 2'd3;  // unused opcode, ignored by the block
  localparam int unsigned DRAIN_CYCLES   = 48;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned POOL_SIZE      = 4;

  // One video command as it leaves the block
  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] offset;
    logic [7:0]  value;
    logic        last;
  } video_cmd_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [7:0]  cfg_data_i    = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = 32'h0;  // [7:0] char_code, [19:8] glyph_index,
                                       // [27:20] glyph_byte, [31:28] zero
  logic [1:0]  s_axis_tuser  = OP_PUT; // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [14:0] byte_offset, [22:15] byte_value, [23] zero
  logic [1:0]  m_axis_tuser;           // [1:0] kind
  logic        m_axis_tlast;

  bitplane_text_console_renderer #(
    .TEXT_LINES(TEXT_LINES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Console state as the block should hold it
  logic       mode_color;
  logic [7:0] text_attr;
  logic [6:0] cur_col;
  logic [4:0] cur_row;
  logic [7:0] glyph_mem [GlyphEntries];
  bit         glyph_loaded [GlyphEntries];

  video_cmd_t pending_cmds [$];
  logic [7:0] char_pool [POOL_SIZE];

  // Traffic shaping
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          rx_hold_req = 1'b0;
  bit          rx_hold_taken = 1'b0;
  int unsigned rx_hold_left = 0;

  // Bookkeeping
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned glyph_loads = 0;
  int unsigned beats_checked = 0;
  int unsigned writes_seen = 0;
  int unsigned scrolls_seen = 0;
  int unsigned line_clears_seen = 0;
  int unsigned screen_clears_seen = 0;
  int unsigned quiet_cycles = 0;
  video_cmd_t  got_cmd;
  video_cmd_t  exp_cmd;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic video_cmd_t make_cmd(logic [1:0] kind, int unsigned off, logic [7:0] val);
    video_cmd_t c;
    c.kind   = kind;
    c.offset = off[14:0];
    c.value  = val;
    c.last   = 1'b0;
    return c;
  endfunction

  // Work out the commands one accepted beat causes and advance the console state
  task automatic render_step(input logic [1:0] op, input logic [7:0] ch,
                             input logic [11:0] gidx, input logic [7:0] gbyte);
    int unsigned cols;
    int unsigned planes;
    int unsigned height;
    int unsigned col;
    int unsigned off;
    int unsigned next_row;
    logic [7:0]  g;
    logic [7:0]  v;
    bit          wrap;
    video_cmd_t  batch [$];
    video_cmd_t  tail;
    cols   = mode_color ? 40 : 80;
    planes = mode_color ? 4 : 1;
    height = mode_color ? 8 : 16;
    col    = cur_col;
    wrap   = 1'b1;
    if (op == OP_LOAD) begin
      glyph_mem[gidx]    = gbyte;
      glyph_loaded[gidx] = 1'b1;
    end else if (op == OP_CLEAR) begin
      batch.push_back(make_cmd(KIND_CLR_SCREEN, 0, 8'h00));
      cur_col = '0;
      cur_row = '0;
    end else if (op == OP_PUT) begin
      if (ch == CH_TAB) begin
        col  = col + 8 - (col & 7);
        wrap = (col >= cols);
      end else if (ch != CH_LF && ch != CH_CR) begin
        // one byte per glyph row and plane
        for (int i = 0; i < height; i++) begin
          g = glyph_mem[(256 * i + ch) % GlyphEntries];
          if (!glyph_loaded[(256 * i + ch) % GlyphEntries])
            $display("bench error: glyph entry %0d drawn before load", 256 * i + ch);
          for (int j = 0; j < planes; j++) begin
            v = (text_attr[j] ? g : 8'h00) | (text_attr[j + 4] ? ~g : 8'h00);
            off = (col & 1) + (col & 32'hffff_fffe) * planes
                + (cur_row * height + i) * cols * planes + 2 * j;
            batch.push_back(make_cmd(KIND_WRITE, off, v));
          end
        end
        col++;
        wrap = (col >= cols);
      end
      if (!wrap) begin
        cur_col = col[6:0];
      end else begin
        cur_col  = '0;
        next_row = cur_row + 1;
        if (next_row >= TEXT_LINES) begin
          cur_row = 5'(TEXT_LINES - 1);
          batch.push_back(make_cmd(KIND_SCROLL, 0, 8'h00));
          batch.push_back(make_cmd(KIND_CLR_LINE,
                                   (TEXT_LINES - 1) * height * planes * cols, 8'h00));
        end else begin
          cur_row = next_row[4:0];
        end
      end
    end
    // flag the final command of this beat, then queue them all
    if (batch.size() > 0) begin
      tail      = batch.pop_back();
      tail.last = 1'b1;
      batch.push_back(tail);
    end
    foreach (batch[k]) pending_cmds.push_back(batch[k]);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned exp_v);
    $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
             $realtime, beats_checked, what, got_v, exp_v);
    mismatches++;
  endtask

  // Offer one beat on the input stream, hold it until taken, then predict
  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input logic [11:0] gidx, input logic [7:0] gbyte);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, gbyte, gidx, ch};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    render_step(op, ch, gidx, gbyte);
    items_sent++;
    if (op == OP_LOAD) glyph_loads++;
  endtask

  // Load whatever rows of this glyph the current mode reads and are still empty
  task automatic ensure_glyph(input logic [7:0] ch);
    int unsigned height;
    int unsigned idx;
    height = mode_color ? 8 : 16;
    for (int i = 0; i < height; i++) begin
      idx = 256 * i + ch;
      if (!glyph_loaded[idx]) send_item(OP_LOAD, 8'($urandom), idx[11:0], 8'($urandom));
    end
  endtask

  task automatic put_char(input logic [7:0] ch);
    if (ch != CH_TAB && ch != CH_LF && ch != CH_CR) ensure_glyph(ch);
    send_item(OP_PUT, ch, 12'($urandom), 8'($urandom));
  endtask

  // Drop valid, wait for every expected command, then let the block go idle
  task automatic settle_outputs();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_COLOR_MODE) mode_color = data[0];
    else text_attr = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_traffic(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Defaults after reset: 80 columns, one plane, attribute 0x07
  task automatic test_reset_state();
    put_char(8'h41);
    put_char(8'h41);
    settle_outputs();
  endtask

  // Glyph bytes and attributes at their extremes in the four-plane mode
  task automatic test_attribute_extremes();
    logic [7:0] attrs [5];
    attrs = '{8'h00, 8'hff, 8'h0f, 8'hf0, 8'h8f};
    write_reg(CFG_COLOR_MODE, 8'd1);
    for (int i = 0; i < 16; i++)
      send_item(OP_LOAD, 8'($urandom), 12'(256 * i), i[0] ? 8'hff : 8'h00);
    send_item(OP_LOAD, 8'($urandom), 12'hfff, 8'($urandom));
    foreach (attrs[k]) begin
      settle_outputs();
      write_reg(CFG_ATTRIBUTE, attrs[k]);
      put_char(8'h00);
      put_char(8'hff);
    end
    settle_outputs();
  endtask

  // Tab, newline, carriage return, clear screen and the ignored opcode
  task automatic test_control_codes();
    write_reg(CFG_COLOR_MODE, 8'd0);
    write_reg(CFG_ATTRIBUTE, 8'($urandom));
    put_char(8'h41);
    put_char(CH_TAB);
    put_char(CH_TAB);
    put_char(CH_LF);
    put_char(8'h41);
    put_char(CH_CR);
    send_item(OP_CLEAR, 8'($urandom), 12'($urandom), 8'($urandom));
    send_item(OP_NONE, 8'($urandom), 12'($urandom), 8'($urandom));
    put_char(8'h41);
    settle_outputs();
  endtask

  // Walk to the last row, then wrap there from the last column (largest burst)
  task automatic test_scroll_bottom();
    write_reg(CFG_COLOR_MODE, 8'd1);
    send_item(OP_CLEAR, 8'($urandom), 12'($urandom), 8'($urandom));
    repeat (TEXT_LINES - 1) put_char(CH_LF);
    repeat (4) put_char(CH_TAB);
    repeat (7) put_char(8'h41);
    put_char(8'h41);
    put_char(CH_CR);
    repeat (5) put_char(CH_TAB);
    settle_outputs();
  endtask

  // Leave the column past the 40-column limit, then draw and tab there
  task automatic test_mode_switch_wrap();
    write_reg(CFG_COLOR_MODE, 8'd0);
    send_item(OP_CLEAR, 8'($urandom), 12'($urandom), 8'($urandom));
    repeat (6) put_char(CH_TAB);
    put_char(8'h41);
    settle_outputs();
    write_reg(CFG_COLOR_MODE, 8'd1);
    put_char(8'h41);
    settle_outputs();
    write_reg(CFG_COLOR_MODE, 8'd0);
    repeat (6) put_char(CH_TAB);
    settle_outputs();
    write_reg(CFG_COLOR_MODE, 8'd1);
    put_char(CH_TAB);
    settle_outputs();
  endtask

  // Mostly text from a small character set, with newline runs to reach the bottom
  task automatic run_random_items(input int unsigned count);
    int unsigned r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 57) put_char(char_pool[$urandom_range(POOL_SIZE - 1)]);
      else if (r < 60) put_char(8'($urandom));
      else if (r < 70) put_char(CH_TAB);
      else if (r < 78) put_char($urandom_range(1) ? CH_LF : CH_CR);
      else if (r < 82) repeat ($urandom_range(20, 6)) put_char(CH_LF);
      else if (r < 84) send_item(OP_CLEAR, 8'($urandom), 12'($urandom), 8'($urandom));
      else if (r < 96) send_item(OP_LOAD, 8'($urandom), 12'($urandom), 8'($urandom));
      else send_item(OP_NONE, 8'($urandom), 12'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_phases();
    logic [7:0] c;
    foreach (char_pool[k]) begin
      c = 8'($urandom);
      if (c == CH_TAB || c == CH_LF || c == CH_CR) c = c ^ 8'h80;
      char_pool[k] = c;
    end
    // receiver mostly stalled
    set_traffic(29, 63);
    write_reg(CFG_ATTRIBUTE, 8'($urandom));
    run_random_items(20);
    settle_outputs();
    // sender mostly idle
    set_traffic(63, 29);
    write_reg(CFG_COLOR_MODE, 8'd0);
    write_reg(CFG_ATTRIBUTE, 8'($urandom));
    run_random_items(20);
    settle_outputs();
    // back to back
    set_traffic(0, 0);
    write_reg(CFG_COLOR_MODE, 8'($urandom_range(1)));
    write_reg(CFG_ATTRIBUTE, 8'($urandom));
    run_random_items(20);
    settle_outputs();
  endtask

  // Receiver holds off while characters keep coming, so the input stalls
  task automatic test_output_backpressure();
    write_reg(CFG_COLOR_MODE, 8'd1);
    write_reg(CFG_ATTRIBUTE, 8'hff);
    foreach (char_pool[k]) ensure_glyph(char_pool[k]);
    rx_hold_req = 1'b1;
    for (int n = 0; n < 8; n++) put_char(char_pool[n % POOL_SIZE]);
    rx_hold_req = 1'b0;
    settle_outputs();
  endtask

  // Sender stops until every command is out, then resumes without a config change
  task automatic test_sender_pause();
    set_traffic(29, 29);
    run_random_items(5);
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    run_random_items(5);
    settle_outputs();
  endtask

  // Receiver: random stalls, or a long hold when asked
  always @(posedge clk_i) begin
    if (!rx_hold_req) rx_hold_taken = 1'b0;
    if (rx_hold_req && !rx_hold_taken) begin
      rx_hold_taken = 1'b1;
      rx_hold_left  = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result beat with the oldest expected command
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_cmd.kind   = m_axis_tuser;
      got_cmd.offset = m_axis_tdata[14:0];
      got_cmd.value  = m_axis_tdata[22:15];
      got_cmd.last   = m_axis_tlast;
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected beat, kind", got_cmd.kind, 0);
      end else begin
        exp_cmd = pending_cmds.pop_front();
        if (got_cmd.kind != exp_cmd.kind) report_mismatch("kind", got_cmd.kind, exp_cmd.kind);
        if (got_cmd.offset != exp_cmd.offset)
          report_mismatch("byte_offset", got_cmd.offset, exp_cmd.offset);
        if (got_cmd.value != exp_cmd.value)
          report_mismatch("byte_value", got_cmd.value, exp_cmd.value);
        if (got_cmd.last != exp_cmd.last) report_mismatch("last", got_cmd.last, exp_cmd.last);
      end
      beats_checked++;
      case (got_cmd.kind)
        KIND_WRITE:    writes_seen++;
        KIND_SCROLL:   scrolls_seen++;
        KIND_CLR_LINE: line_clears_seen++;
        default:       screen_clears_seen++;
      endcase
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles, %0d commands outstanding",
               $realtime, quiet_cycles, pending_cmds.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    mode_color = 1'b0;
    text_attr  = ATTR_RESET;
    cur_col    = '0;
    cur_row    = '0;
    foreach (glyph_loaded[k]) glyph_loaded[k] = 1'b0;
    set_traffic(29, 63);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_attribute_extremes();
    test_control_codes();
    test_scroll_bottom();
    test_mode_switch_wrap();
    test_random_phases();
    test_output_backpressure();
    test_sender_pause();

    $display("ran %0d input beats (%0d glyph loads) through both modes and attribute extremes",
             items_sent, glyph_loads);
    $display("checked %0d results: %0d writes, %0d scrolls, %0d line clears, %0d screen clears",
             beats_checked, writes_seen, scrolls_seen, line_clears_seen, screen_clears_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
